### design/lmr_pkg.sv
// ----------------------------------------------------------------------------
// lmr_pkg
// Shared types, codes and saturation helpers for the linear mixture
// residual block.
// ----------------------------------------------------------------------------
`default_nettype none

package lmr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RECON_W  = 32;
  localparam int ACC_W    = 40;
  localparam int FRAC_W   = 14;
  localparam int CFG_W    = 9;

  // request modes
  localparam logic [1:0] MODE_COEF   = 2'd0;
  localparam logic [1:0] MODE_ABUND  = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;

  // configuration register indexes
  localparam logic CFG_BANDS   = 1'b0;
  localparam logic CFG_MEMBERS = 1'b1;

  typedef struct packed {
    logic start;
    logic load_coef;
    logic load_abund;
    logic rd_en;
    logic do_recon;
    logic do_diff;
    logic do_out;
  } lmr_cmd_t;

  typedef struct packed {
    logic out_free;
  } lmr_status_t;

  function automatic logic signed [RECON_W-1:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (x > hi) begin
      sat32 = hi[RECON_W-1:0];
    end else if (x < lo) begin
      sat32 = lo[RECON_W-1:0];
    end else begin
      sat32 = x[RECON_W-1:0];
    end
  endfunction

  function automatic logic signed [ACC_W-1:0] sat40(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd549755813887;
    lo = -64'sd549755813888;
    if (x > hi) begin
      sat40 = hi[ACC_W-1:0];
    end else if (x < lo) begin
      sat40 = lo[ACC_W-1:0];
    end else begin
      sat40 = x[ACC_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### design/lmr_in_if.sv
// ----------------------------------------------------------------------------
// lmr_in_if
// Request channel: mode, band, endmember and value with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  band_index;
  logic [3:0]  member_index;
  logic signed [15:0] value;

  modport source (output valid, mode, band_index, member_index, value, input ready);
  modport sink   (input valid, mode, band_index, member_index, value, output ready);
endinterface

`default_nettype wire

### design/lmr_out_if.sv
// ----------------------------------------------------------------------------
// lmr_out_if
// Result channel: reconstructed band, difference and running residual.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmr_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         out_band;
  logic signed [31:0] reconstructed;
  logic signed [31:0] difference;
  logic signed [39:0] residual_total;
  logic               last_band;

  modport source (output valid, out_band, reconstructed, difference, residual_total,
                  last_band, input ready);
  modport sink   (input valid, out_band, reconstructed, difference, residual_total,
                  last_band, output ready);
endinterface

`default_nettype wire

### design/linear_mixture_residual.sv
// A sample runs the single multiply-accumulate unit over the endmembers in
// use, one table entry per cycle, then the drain, reconstruction, difference
// and output states; output waits for a free output register, and no new
// request is taken until then. Table and abundance loads give no result.
// Reset: bands_used 256, endmembers_used 4, residual accumulator zero;
// coefficient table and abundances are undefined until written.
// ----------------------------------------------------------------------------
// linear_mixture_residual
// Linear mixing model reconstruction of a hyperspectral pixel with a
// running signed residual over its bands.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_mixture_residual #(
  parameter int MAX_BANDS      = 256,
  parameter int MAX_ENDMEMBERS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  lmr_in_if.sink                         in_ch,
  lmr_out_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [lmr_pkg::CFG_W-1:0] cfg_data
);

  localparam int MW    = $clog2(MAX_ENDMEMBERS);
  localparam int TOP_B = (MAX_BANDS < 256) ? MAX_BANDS : 256;

  logic [8:0]           cfg_bands_r;
  logic [4:0]           cfg_members_r;
  logic [8:0]           bands_eff;
  logic [7:0]           band_last;
  logic [MW-1:0]        member_last;
  logic [MW-1:0]        k_idx;
  lmr_pkg::lmr_cmd_t    cmd;
  lmr_pkg::lmr_status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_bands_r   <= 9'd256;
      cfg_members_r <= 5'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        lmr_pkg::CFG_BANDS:   cfg_bands_r   <= cfg_data;
        lmr_pkg::CFG_MEMBERS: cfg_members_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // clamp the registers to what storage supports
  always_comb begin
    if (cfg_bands_r == 9'd0) begin
      bands_eff = 9'd1;
    end else if (int'(cfg_bands_r) > TOP_B) begin
      bands_eff = 9'(TOP_B);
    end else begin
      bands_eff = cfg_bands_r;
    end
    band_last = 8'(bands_eff - 9'd1);

    if (cfg_members_r == 5'd0) begin
      member_last = '0;
    end else if (int'(cfg_members_r) > MAX_ENDMEMBERS) begin
      member_last = MW'(MAX_ENDMEMBERS - 1);
    end else begin
      member_last = MW'(cfg_members_r - 5'd1);
    end
  end

  lmr_ctrl #(
    .MAX_ENDMEMBERS (MAX_ENDMEMBERS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_mode     (in_ch.mode),
    .member_last (member_last),
    .status      (status),
    .in_ready    (in_ch.ready),
    .cmd         (cmd),
    .k_idx       (k_idx)
  );

  lmr_dpath #(
    .MAX_BANDS      (MAX_BANDS),
    .MAX_ENDMEMBERS (MAX_ENDMEMBERS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .k_idx     (k_idx),
    .band_last (band_last),
    .in_band   (in_ch.band_index),
    .in_member (in_ch.member_index),
    .in_value  (in_ch.value),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_band  (out_ch.out_band),
    .out_recon (out_ch.reconstructed),
    .out_diff  (out_ch.difference),
    .out_resid (out_ch.residual_total),
    .out_last  (out_ch.last_band),
    .status    (status)
  );

endmodule

`default_nettype wire

### design/lmr_ram.sv
// ----------------------------------------------------------------------------
// lmr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lmr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/lmr_ctrl.sv
// ----------------------------------------------------------------------------
// lmr_ctrl
// Sequencer: takes requests, steps the shared multiply-accumulate over the
// endmembers, then runs the reconstruction, difference and output steps.
// ----------------------------------------------------------------------------
`default_nettype none

module lmr_ctrl #(
  parameter int MAX_ENDMEMBERS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  input  wire logic [1:0]                        in_mode,
  input  wire logic [$clog2(MAX_ENDMEMBERS)-1:0] member_last,
  input  wire lmr_pkg::lmr_status_t              status,
  output      logic                              in_ready,
  output      lmr_pkg::lmr_cmd_t                 cmd,
  output      logic [$clog2(MAX_ENDMEMBERS)-1:0] k_idx
);

  localparam int MW = $clog2(MAX_ENDMEMBERS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MAC    = 3'd1;
  localparam logic [2:0] S_DRAIN1 = 3'd2;
  localparam logic [2:0] S_DRAIN2 = 3'd3;
  localparam logic [2:0] S_RECON  = 3'd4;
  localparam logic [2:0] S_DIFF   = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [MW-1:0] k_r, k_nxt;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_mode)
            lmr_pkg::MODE_COEF:  cmd.load_coef  = 1'b1;
            lmr_pkg::MODE_ABUND: cmd.load_abund = 1'b1;
            lmr_pkg::MODE_SAMPLE: begin
              cmd.start = 1'b1;
              k_nxt     = '0;
              state_nxt = S_MAC;
            end
            default: ;  // drop unused mode
          endcase
        end
      end
      S_MAC: begin
        cmd.rd_en = 1'b1;
        if (k_r == member_last) begin
          state_nxt = S_DRAIN1;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_DRAIN1: state_nxt = S_DRAIN2;
      S_DRAIN2: state_nxt = S_RECON;
      S_RECON: begin
        cmd.do_recon = 1'b1;
        state_nxt    = S_DIFF;
      end
      S_DIFF: begin
        cmd.do_diff = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.do_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign k_idx = k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

`default_nettype wire

### design/lmr_dpath.sv
// ----------------------------------------------------------------------------
// lmr_dpath
// Coefficient table, abundance store, multiply-accumulate pipeline,
// saturation stages, residual accumulator and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lmr_dpath #(
  parameter int MAX_BANDS      = 256,
  parameter int MAX_ENDMEMBERS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire lmr_pkg::lmr_cmd_t                 cmd,
  input  wire logic [$clog2(MAX_ENDMEMBERS)-1:0] k_idx,
  input  wire logic [7:0]                        band_last,
  input  wire logic [7:0]                        in_band,
  input  wire logic [3:0]                        in_member,
  input  wire logic signed [15:0]                in_value,
  input  wire logic                              out_ready,
  output      logic                              out_valid,
  output      logic [7:0]                        out_band,
  output      logic signed [31:0]                out_recon,
  output      logic signed [31:0]                out_diff,
  output      logic signed [39:0]                out_resid,
  output      logic                              out_last,
  output      lmr_pkg::lmr_status_t              status
);

  localparam int TAB_DEPTH = MAX_BANDS * MAX_ENDMEMBERS;
  localparam int AW        = $clog2(TAB_DEPTH);
  localparam int MW        = $clog2(MAX_ENDMEMBERS);
  localparam int SUM_W     = 2 * lmr_pkg::SAMPLE_W + 1 + MW;

  logic signed [lmr_pkg::SAMPLE_W-1:0] abund_r [MAX_ENDMEMBERS];
  logic signed [lmr_pkg::SAMPLE_W-1:0] abd_q_r;
  logic [lmr_pkg::SAMPLE_W-1:0]        ram_rdata;
  logic [AW-1:0]                       wr_addr, rd_addr;
  logic                                member_ok, band_ok;

  logic [7:0]                          band_r;
  logic signed [lmr_pkg::SAMPLE_W-1:0] val_r;
  logic                                band_ok_r;
  logic                                v1_r, v2_r;
  logic signed [2*lmr_pkg::SAMPLE_W-1:0] prod_r, prod_nxt;
  logic signed [SUM_W-1:0]             sum_r;
  logic signed [lmr_pkg::RECON_W-1:0]  recon_r, diff_r;
  logic signed [lmr_pkg::ACC_W-1:0]    acc_r, acc_nxt;
  logic                                out_valid_r;
  logic                                last_nxt;

  assign member_ok = int'(in_member) < MAX_ENDMEMBERS;
  assign band_ok   = int'(in_band) < MAX_BANDS;
  assign wr_addr   = AW'(int'(in_band) * MAX_ENDMEMBERS + int'(in_member));
  assign rd_addr   = AW'(int'(band_r) * MAX_ENDMEMBERS + int'(k_idx));

  lmr_ram #(
    .WIDTH (lmr_pkg::SAMPLE_W),
    .DEPTH (TAB_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cmd.load_coef && member_ok && band_ok),
    .waddr (wr_addr),
    .wdata (in_value),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_abund && member_ok) begin
      abund_r[MW'(in_member)] <= in_value;
    end
    if (cmd.rd_en) begin
      abd_q_r <= abund_r[k_idx];
    end
  end

  // a band outside the table contributes nothing
  always_comb begin
    prod_nxt = '0;
    if (band_ok_r) begin
      prod_nxt = $signed(ram_rdata) * abd_q_r;
    end
  end

  always_comb begin
    acc_nxt  = lmr_pkg::sat40(64'(acc_r) + 64'(diff_r));
    last_nxt = (band_r == band_last);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      band_r    <= in_band;
      val_r     <= in_value;
      band_ok_r <= band_ok;
    end
    prod_r <= prod_nxt;
    if (cmd.start) begin
      sum_r <= '0;
    end else if (v2_r) begin
      sum_r <= sum_r + SUM_W'(prod_r);
    end
    // arithmetic shift gives floor rounding
    if (cmd.do_recon) begin
      recon_r <= lmr_pkg::sat32(64'(sum_r >>> lmr_pkg::FRAC_W));
    end
    if (cmd.do_diff) begin
      diff_r <= lmr_pkg::sat32(64'(recon_r) - 64'(val_r));
    end
    if (cmd.do_out) begin
      out_band  <= band_r;
      out_recon <= recon_r;
      out_diff  <= diff_r;
      out_resid <= acc_nxt;
      out_last  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
      if (cmd.do_out) begin
        acc_r       <= last_nxt ? '0 : acc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign status.out_free = !out_valid_r || out_ready;

endmodule

`default_nettype wire

### sim/linear_mixture_residual_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_mixture_residual_test
// Self-checking bench for the linear mixture residual block. Loads endmember
// coefficients and abundances, streams observed band samples and compares
// every band result against an in-bench mixing and residual calculation.
// Runs under several band and endmember settings, including clamped ones,
// with mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module linear_mixture_residual_test;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 32;
  localparam int STALL_LIMIT   = 3000;

  localparam logic signed [63:0] RECON_HI = 64'sd2147483647;
  localparam logic signed [63:0] RECON_LO = -64'sd2147483648;
  localparam logic signed [63:0] ACC_HI   = 64'sd549755813887;
  localparam logic signed [63:0] ACC_LO   = -64'sd549755813888;

  typedef struct packed {
    logic [7:0]         band;
    logic signed [31:0] recon;
    logic signed [31:0] diff;
    logic signed [39:0] resid;
    logic               last;
  } band_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [lmr_pkg::CFG_W-1:0] cfg_data;

  lmr_in_if  in_ch();
  lmr_out_if out_ch();

  linear_mixture_residual dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // bench copy of the block state
  logic signed [15:0] coef_mem [0:4095];
  logic signed [15:0] abund_mem [0:15];
  logic signed [63:0] resid_acc;
  logic [8:0]         bands_reg;
  logic [4:0]         members_reg;

  // entries that stimulus has written, so no sample reads an empty one
  bit coef_set [0:4095];
  bit abund_set [0:15];

  band_result_t band_results_q [$];

  int gap_pct;
  int stall_pct;
  int items_sent;
  int results_checked;
  int last_bands_seen;
  int error_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic signed [63:0] clip(input logic signed [63:0] x,
                                              input logic signed [63:0] lo,
                                              input logic signed [63:0] hi);
    if (x < lo) begin
      return lo;
    end else if (x > hi) begin
      return hi;
    end
    return x;
  endfunction

  function automatic int bands_in_use();
    int b;
    b = int'(bands_reg);
    if (b < 1) b = 1;
    if (b > 256) b = 256;
    return b;
  endfunction

  function automatic int members_in_use();
    int m;
    m = int'(members_reg);
    if (m < 1) m = 1;
    if (m > 16) m = 16;
    return m;
  endfunction

  // Record a load, or mix abundances and coefficients and update the residual.
  function automatic void mix_and_accumulate(input logic [1:0] mode,
                                             input logic [7:0] band,
                                             input logic [3:0] member,
                                             input logic signed [15:0] value);
    logic signed [63:0] mac;
    logic signed [63:0] recon;
    logic signed [63:0] diff;
    band_result_t r;
    int m;
    case (mode)
      lmr_pkg::MODE_COEF: begin
        coef_mem[{band, member}] = value;
      end
      lmr_pkg::MODE_ABUND: begin
        abund_mem[member] = value;
      end
      lmr_pkg::MODE_SAMPLE: begin
        m = members_in_use();
        mac = 64'sd0;
        for (int k = 0; k < m; k++) begin
          mac += abund_mem[k] * coef_mem[{band, k[3:0]}];
        end
        // arithmetic shift floors negative sums
        recon = clip(mac >>> lmr_pkg::FRAC_W, RECON_LO, RECON_HI);
        diff = clip(recon - value, RECON_LO, RECON_HI);
        resid_acc = clip(resid_acc + diff, ACC_LO, ACC_HI);
        r.band = band;
        r.recon = recon[31:0];
        r.diff = diff[31:0];
        r.resid = resid_acc[39:0];
        r.last = (int'(band) == bands_in_use() - 1);
        band_results_q.push_back(r);
        if (r.last) resid_acc = 64'sd0;
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      mix_and_accumulate(in_ch.mode, in_ch.band_index, in_ch.member_index, in_ch.value);
    end
  end

  always @(posedge clk) begin : check_result
    band_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (band_results_q.size() == 0) begin
        $error("result for band %0d with no sample outstanding", out_ch.out_band);
        error_count++;
      end else begin
        want = band_results_q.pop_front();
        results_checked++;
        if (want.last) last_bands_seen++;
        if (out_ch.out_band !== want.band) begin
          $error("out_band expected %0d got %0d", want.band, out_ch.out_band);
          error_count++;
        end
        if (out_ch.reconstructed !== want.recon) begin
          $error("reconstructed expected %0d got %0d", want.recon, out_ch.reconstructed);
          error_count++;
        end
        if (out_ch.difference !== want.diff) begin
          $error("difference expected %0d got %0d", want.diff, out_ch.difference);
          error_count++;
        end
        if (out_ch.residual_total !== want.resid) begin
          $error("residual_total expected %0d got %0d", want.resid, out_ch.residual_total);
          error_count++;
        end
        if (out_ch.last_band !== want.last) begin
          $error("last_band expected %0d got %0d", want.last, out_ch.last_band);
          error_count++;
        end
      end
    end
  end

  // End the run if nothing moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
    $display("linear_mixture_residual_test failed");
    $finish;
  end

  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(15))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic send_request(input logic [1:0] mode, input logic [7:0] band,
                              input logic [3:0] member, input logic signed [15:0] value);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.mode = mode;
    in_ch.band_index = band;
    in_ch.member_index = member;
    in_ch.value = value;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic load_coef(input int band, input int member, input logic signed [15:0] value);
    coef_set[band * 16 + member] = 1'b1;
    send_request(lmr_pkg::MODE_COEF, band[7:0], member[3:0], value);
  endtask

  task automatic load_abund(input int member, input logic signed [15:0] value);
    abund_set[member] = 1'b1;
    send_request(lmr_pkg::MODE_ABUND, 8'($urandom), member[3:0], value);
  endtask

  // Fill whatever the band's reconstruction would read, then send the sample.
  task automatic send_sample(input int band, input int em, input logic signed [15:0] value);
    for (int k = 0; k < em; k++) begin
      if (!abund_set[k]) load_abund(k, rand_value());
      if (!coef_set[band * 16 + k]) load_coef(band, k, rand_value());
    end
    send_request(lmr_pkg::MODE_SAMPLE, band[7:0], 4'($urandom), value);
  endtask

  // Drop the request, let every result drain, then let the block settle.
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (band_results_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic index, input int data);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_data = data[lmr_pkg::CFG_W-1:0];
    if (index == lmr_pkg::CFG_BANDS) begin
      bands_reg = data[8:0];
    end else begin
      members_reg = data[4:0];
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Reset settings: four endmembers, 256 bands; extremes of every field.
  task automatic test_reset_defaults();
    load_abund(0, 16'sd16384);
    load_abund(1, 16'sh8000);
    load_abund(2, 16'sh7fff);
    load_abund(3, 16'shffff);
    load_coef(0, 0, 16'sh7fff);
    load_coef(0, 1, 16'sh8000);
    load_coef(0, 2, 16'sd1);
    load_coef(0, 3, 16'sd0);
    load_coef(255, 0, 16'sh8000);
    load_coef(255, 1, 16'sh8000);
    load_coef(255, 2, 16'sh7fff);
    load_coef(255, 3, 16'sh8000);
    load_coef(128, 15, 16'sh5a5a);
    send_request(MODE_UNUSED, 8'd255, 4'd15, 16'shffff);
    send_sample(0, 4, 16'sh8000);
    send_sample(0, 4, 16'sh7fff);
    // last band closes the pixel and clears the running residual
    send_sample(255, 4, 16'sd0);
    send_sample(255, 4, 16'sh8000);
    send_sample(0, 4, 16'sd0);
    wait_idle();
  endtask

  task automatic send_pixel(input int eb, input int em, input int stop);
    int first;
    if ($urandom_range(3) == 0) begin
      for (int k = 0; k < em; k++) load_abund(k, rand_value());
    end
    // with many bands, sweep only the tail so the last band is reached
    first = (eb > 16) ? eb - $urandom_range(8, 1) : 0;
    for (int b = first; b < eb && items_sent < stop; b++) begin
      if ($urandom_range(24) == 0) return;
      case ($urandom_range(19))
        0: send_request(MODE_UNUSED, 8'($urandom), 4'($urandom), rand_value());
        1: load_coef($urandom_range(255), $urandom_range(15), rand_value());
        2: if (eb < 256) send_sample($urandom_range(255, eb), em, rand_value());
        3: load_abund($urandom_range(15), rand_value());
        default: ;
      endcase
      if ($urandom_range(5) == 0) load_coef(b, $urandom_range(em - 1), rand_value());
      send_sample(b, em, rand_value());
    end
  endtask

  task automatic run_phase(input int bands, input int members, input int gap,
                           input int stall, input int quota);
    int eb;
    int em;
    int stop;
    wait_idle();
    gap_pct = gap;
    stall_pct = stall;
    write_reg(lmr_pkg::CFG_BANDS, bands);
    write_reg(lmr_pkg::CFG_MEMBERS, members);
    eb = bands_in_use();
    em = members_in_use();
    stop = items_sent + quota;
    while (items_sent < stop) send_pixel(eb, em, stop);
  endtask

  task automatic test_random_pixels();
    run_phase(4, 4, 0, 0, 120);
    run_phase(3, 16, 56, 0, 120);
    run_phase(0, 1, 0, 56, 100);
    run_phase(8, 2, 29, 29, 120);
    run_phase(511, 0, 0, 0, 100);
    run_phase(6, 31, 29, 29, 100);
    run_phase(256, 16, 0, 56, 150);
    run_phase(1, 16, 0, 0, 100);
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = lmr_pkg::CFG_BANDS;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = lmr_pkg::MODE_COEF;
    in_ch.band_index = '0;
    in_ch.member_index = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    results_checked = 0;
    last_bands_seen = 0;
    error_count = 0;
    resid_acc = 64'sd0;
    bands_reg = 9'd256;
    members_reg = 5'd4;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_random_pixels();

    $display("%0d requests sent, %0d band results checked, %0d pixels closed on a last band",
             items_sent, results_checked, last_bands_seen);
    $display("settings ranged from 1 to 256 bands and 1 to 16 endmembers, clamped values too");
    if (error_count == 0) begin
      $display("linear_mixture_residual_test passed");
    end else begin
      $display("linear_mixture_residual_test failed");
    end
    $finish;
  end

endmodule
